### rtl/epre_pkg.sv
// Shared constants, codes and types of the entropy pool range extractor.
package epre_pkg;

  localparam int POOL_DEPTH    = 512;
  localparam int IDX_W         = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int SLOT_W        = 9;
  localparam int WORD_W        = 64;
  localparam int MASK_BITS     = 8;
  localparam int NBITS_W       = 4;
  localparam int PCT_W         = 8;
  localparam int PERCENT_SCALE = 100;
  localparam int DIV_CNT_W     = $clog2(WORD_W);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_RANGE = 2'd1;
  localparam logic [1:0] OP_MASK  = 2'd2;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
  } pool_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/epre_if.sv
// Valid/ready channel interfaces for items in and results out.
interface epre_in_if import epre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [SLOT_W-1:0] load_slot;
  logic [WORD_W-1:0] entropy_word;
  logic [WORD_W-1:0] range_min;
  logic [WORD_W-1:0] range_max;
  logic [NBITS_W-1:0] bit_count;
  logic [PCT_W-1:0]  percent;

  modport source (output valid, opcode, load_slot, entropy_word, range_min, range_max,
                  bit_count, percent, input ready);
  modport sink   (input valid, opcode, load_slot, entropy_word, range_min, range_max,
                  bit_count, percent, output ready);
endinterface

interface epre_out_if import epre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] value;
  logic              refill_due;

  modport source (output valid, value, refill_due, input ready);
  modport sink   (input valid, value, refill_due, output ready);
endinterface

### rtl/epre_pool.sv
// Entropy pool memory: one write port, one read port with registered data.
module epre_pool import epre_pkg::*; (
  input  logic              clk,
  input  pool_wr_t          wr,
  input  logic [IDX_W-1:0]  raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [POOL_DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/epre_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module epre_div import epre_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output div_stat_t         stat,
  output logic [WORD_W-1:0] quotient,
  output logic [WORD_W-1:0] remainder
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(WORD_W - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WORD_W-1:0]    q_r, q_nxt;
  logic [WORD_W-1:0]    rem_r, rem_nxt;
  logic [WORD_W-1:0]    dvs_r;
  logic [WORD_W:0]      trial;
  logic [WORD_W+1:0]    diff;
  logic                 ge;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial   = {rem_r, q_r[WORD_W-1]};
    diff    = {1'b0, trial} - {2'b00, dvs_r};
    ge      = ~diff[WORD_W+1];
    rem_nxt = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    q_nxt   = {q_r[WORD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

### rtl/entropy_pool_range_extractor_top.sv
// Top level of the entropy pool range extractor.
// One item is taken at a time and gives exactly one result. A load, an unused
// opcode, a full-span range draw and a mask draw of zero bits go straight to
// the done state. A range draw runs index advance, pool read, divider start,
// 64 divide steps and a done flag in the bit-serial dividers, write-back, then
// the output register load. A mask draw of n bits (n saturated at 8) repeats
// the steps from index advance to write-back once per bit, each bit being one
// draw modulo 100. The rate is set by the 64-step divider; two of them run
// side by side, one for the pool word and one for the precision estimate
// (precision/(2*range) is computed as (precision>>1)/range). The next item is
// taken while a finished result still waits in the output register. Pool
// words are undefined until loaded; drawing from an unloaded word gives an
// undefined value. refill_due marks a result whose draws wrapped the index.
module entropy_pool_range_extractor_top import epre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  epre_in_if.sink   in_ch,
  epre_out_if.source out_ch
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADV  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_DIVS = 3'd3;
  localparam logic [2:0] ST_DIVW = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL_DEPTH - 1);

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [WORD_W-1:0] prec_r, prec_nxt;
  logic              out_valid_r, out_valid_nxt;

  // per-item working registers
  logic [WORD_W-1:0]  range_r, range_nxt;
  logic [WORD_W-1:0]  min_r, min_nxt;
  logic [PCT_W-1:0]   pct_r, pct_nxt;
  logic [NBITS_W-1:0] nbits_r, nbits_nxt;
  logic [NBITS_W-1:0] biti_r, biti_nxt;
  logic               is_mask_r, is_mask_nxt;
  logic [WORD_W-1:0]  value_r, value_nxt;
  logic               wrapped_r, wrapped_nxt;
  logic [WORD_W-1:0]  out_value_r, out_value_nxt;
  logic               out_refill_r, out_refill_nxt;

  logic               in_xfer;
  logic [WORD_W-1:0]  acc_range;
  logic [NBITS_W-1:0] acc_nbits;
  pool_wr_t           pool_wr;
  logic [WORD_W-1:0]  pool_rdata;
  logic               div_start;
  div_stat_t          word_stat, prec_stat;
  logic [WORD_W-1:0]  word_q, word_rem, prec_q, prec_rem_unused;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign acc_range   = in_ch.range_max - in_ch.range_min + 64'd1;
  assign acc_nbits   = (in_ch.bit_count > NBITS_W'(MASK_BITS)) ? NBITS_W'(MASK_BITS)
                                                                : in_ch.bit_count;
  assign div_start   = (state_r == ST_DIVS);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    prec_nxt       = prec_r;
    out_valid_nxt  = out_valid_r;
    range_nxt      = range_r;
    min_nxt        = min_r;
    pct_nxt        = pct_r;
    nbits_nxt      = nbits_r;
    biti_nxt       = biti_r;
    is_mask_nxt    = is_mask_r;
    value_nxt      = value_r;
    wrapped_nxt    = wrapped_r;
    out_value_nxt  = out_value_r;
    out_refill_nxt = out_refill_r;
    pool_wr        = '0;

    // output register drains independently of the work side
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          value_nxt   = '0;
          wrapped_nxt = 1'b0;
          biti_nxt    = '0;
          pct_nxt     = in_ch.percent;
          state_nxt   = ST_DONE;
          case (in_ch.opcode)
            OP_LOAD: begin
              if (32'(in_ch.load_slot) < POOL_DEPTH) begin
                pool_wr.we    = 1'b1;
                pool_wr.waddr = IDX_W'(in_ch.load_slot);
                pool_wr.wdata = in_ch.entropy_word;
              end
            end
            OP_RANGE: begin
              is_mask_nxt = 1'b0;
              range_nxt   = acc_range;
              min_nxt     = in_ch.range_min;
              value_nxt   = in_ch.range_min;   // full-span draw returns min
              if (acc_range != '0) begin
                state_nxt = ST_ADV;
              end
            end
            OP_MASK: begin
              is_mask_nxt = 1'b1;
              range_nxt   = WORD_W'(PERCENT_SCALE);
              min_nxt     = '0;
              nbits_nxt   = acc_nbits;
              if (acc_nbits != '0) begin
                state_nxt = ST_ADV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADV: begin
        // word used up: step to the next one, restore full precision
        if (prec_r <= range_r) begin
          prec_nxt = '1;
          if (idx_r == IDX_LAST) begin
            idx_nxt     = '0;
            wrapped_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (word_stat.done && prec_stat.done) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        pool_wr.we    = 1'b1;
        pool_wr.waddr = idx_r;
        pool_wr.wdata = word_q;
        prec_nxt      = range_r[WORD_W-1] ? '0 : prec_q;
        if (is_mask_r) begin
          if (word_rem < WORD_W'(pct_r)) begin
            value_nxt = value_r | (WORD_W'(1) << biti_r);
          end
          biti_nxt = biti_r + 1'b1;
          state_nxt = (biti_r + 1'b1 == nbits_r) ? ST_DONE : ST_ADV;
        end else begin
          value_nxt = min_r + word_rem;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = value_r;
          out_refill_nxt = wrapped_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= IDX_LAST;
      prec_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      prec_r      <= prec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    range_r      <= range_nxt;
    min_r        <= min_nxt;
    pct_r        <= pct_nxt;
    nbits_r      <= nbits_nxt;
    biti_r       <= biti_nxt;
    is_mask_r    <= is_mask_nxt;
    value_r      <= value_nxt;
    wrapped_r    <= wrapped_nxt;
    out_value_r  <= out_value_nxt;
    out_refill_r <= out_refill_nxt;
  end

  epre_pool u_pool (
    .clk   (clk),
    .wr    (pool_wr),
    .raddr (idx_r),
    .rdata (pool_rdata)
  );

  // pool word divided by the range
  epre_div u_div_word (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (pool_rdata),
    .divisor   (range_r),
    .stat      (word_stat),
    .quotient  (word_q),
    .remainder (word_rem)
  );

  // precision over twice the range, as half the precision over the range
  epre_div u_div_prec (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (prec_r >> 1),
    .divisor   (range_r),
    .stat      (prec_stat),
    .quotient  (prec_q),
    .remainder (prec_rem_unused)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_value_r;
  assign out_ch.refill_due = out_refill_r;

endmodule

### rtl/epre_checker.sv
// Port-level checker for the extractor, bound to the top level.
module epre_checker import epre_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_value,
  input logic              out_refill_due
);

  logic       in_xfer, out_xfer;
  logic [1:0] pend_r, pend_nxt;

  assign in_xfer  = in_valid & in_ready;
  assign out_xfer = out_valid & out_ready;

  // items accepted whose result has not yet been transferred
  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_refill_due))
    else $error("result changed while stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> pend_r <= 2'd1)
    else $error("item accepted with a result already waiting and one in work");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result shown with no item outstanding");

endmodule

bind entropy_pool_range_extractor_top epre_checker u_epre_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_value      (out_ch.value),
  .out_refill_due (out_ch.refill_due)
);
